// ----- src/bfma_pkg.sv -----
// Package with the types and constants of the BN254 scalar-field ALU.
package bfma_pkg;

    localparam int LIMB_BITS  = 64;
    localparam int LIMB_COUNT = 4;
    localparam int WORD_BITS  = LIMB_BITS * LIMB_COUNT;
    localparam int ACC_BITS   = WORD_BITS + 2;
    localparam int SUM_BITS   = WORD_BITS + LIMB_BITS + 2;
    localparam int STAGES_PER_ROUND = 8;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    localparam logic [WORD_BITS-1:0] PRIME =
        256'h30644e72e131a029b85045b68181585d2833e84879b9709143e1f593f0000001;
    localparam logic [LIMB_BITS-1:0] NEG_PINV = 64'hc2e1f593efffffff;

    typedef struct packed {
        logic [1:0]           mode;
        logic [LIMB_BITS-1:0] a_limb0;
        logic [LIMB_BITS-1:0] a_limb1;
        logic [LIMB_BITS-1:0] a_limb2;
        logic [LIMB_BITS-1:0] a_limb3;
        logic [LIMB_BITS-1:0] b_limb0;
        logic [LIMB_BITS-1:0] b_limb1;
        logic [LIMB_BITS-1:0] b_limb2;
        logic [LIMB_BITS-1:0] b_limb3;
    } t_in;

    typedef struct packed {
        logic [LIMB_BITS-1:0] r_limb0;
        logic [LIMB_BITS-1:0] r_limb1;
        logic [LIMB_BITS-1:0] r_limb2;
        logic [LIMB_BITS-1:0] r_limb3;
    } t_out;

    typedef struct packed {
        logic [1:0]           mode;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } t_ctx;

endpackage

// ----- src/bfma_round.sv -----
// One pipelined CIOS Montgomery round: accumulate a_i*B, derive m, add m*p and shift.
module bfma_round #(
    parameter int ROUND = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  bfma_pkg::t_ctx                i_ctx,
    input  logic [bfma_pkg::ACC_BITS-1:0] i_t,
    output logic                          o_valid,
    output bfma_pkg::t_ctx                o_ctx,
    output logic [bfma_pkg::ACC_BITS-1:0] o_t
);

    localparam int LB = bfma_pkg::LIMB_BITS;
    localparam int HB = LB / 2;
    localparam int NL = bfma_pkg::LIMB_COUNT;
    localparam int SW = bfma_pkg::SUM_BITS;
    localparam int AW = bfma_pkg::ACC_BITS;
    localparam int NS = bfma_pkg::STAGES_PER_ROUND;

    function automatic logic [4*LB-1:0] partials(input logic [LB-1:0] x,
                                                 input logic [LB-1:0] y);
        logic [4*LB-1:0] res;
        res[0*LB +: LB] = LB'(x[HB-1:0]) * LB'(y[HB-1:0]);
        res[1*LB +: LB] = LB'(x[HB-1:0]) * LB'(y[LB-1:HB]);
        res[2*LB +: LB] = LB'(x[LB-1:HB]) * LB'(y[HB-1:0]);
        res[3*LB +: LB] = LB'(x[LB-1:HB]) * LB'(y[LB-1:HB]);
        return res;
    endfunction

    function automatic logic [2*LB-1:0] combine(input logic [4*LB-1:0] pp);
        return (2*LB)'(pp[0*LB +: LB]) + ((2*LB)'(pp[1*LB +: LB]) << HB)
             + ((2*LB)'(pp[2*LB +: LB]) << HB) + ((2*LB)'(pp[3*LB +: LB]) << LB);
    endfunction

    logic [NS-1:0]         r_v;
    bfma_pkg::t_ctx        r_ctx [NS];
    logic [AW-1:0]         r1_t;
    logic [AW-1:0]         r2_t;
    logic [4*LB-1:0]       r1_pp [NL];
    logic [2*LB-1:0]       r2_pr [NL];
    logic [SW-1:0]         r3_t;
    logic [SW-1:0]         r4_t;
    logic [SW-1:0]         r5_t;
    logic [SW-1:0]         r6_t;
    logic [SW-1:0]         r7_t;
    logic [LB-1:0]         r4_q00;
    logic [HB-1:0]         r4_q01;
    logic [HB-1:0]         r4_q10;
    logic [LB-1:0]         r5_m;
    logic [4*LB-1:0]       r6_pp [NL];
    logic [2*LB-1:0]       r7_pr [NL];
    logic [AW-1:0]         r8_t;
    logic [LB-1:0]         w_ai;
    logic [LB-1:0]         w_t0;
    logic [SW-1:0]         n_t8;

    assign w_ai = i_ctx.a[ROUND*LB +: LB];
    assign w_t0 = r3_t[LB-1:0];
    assign n_t8 = SW'(r7_t) + SW'({r7_pr[2], r7_pr[0]}) + (SW'({r7_pr[3], r7_pr[1]}) << LB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int s = 1; s < NS; s++) begin
                r_ctx[s] <= r_ctx[s-1];
            end
            r1_t <= i_t;
            for (int j = 0; j < NL; j++) begin
                r1_pp[j] <= partials(w_ai, i_ctx.b[j*LB +: LB]);
            end
            r2_t <= r1_t;
            for (int j = 0; j < NL; j++) begin
                r2_pr[j] <= combine(r1_pp[j]);
            end
            r3_t <= SW'(r2_t) + SW'({r2_pr[2], r2_pr[0]})
                  + (SW'({r2_pr[3], r2_pr[1]}) << LB);
            r4_t   <= r3_t;
            r4_q00 <= LB'(w_t0[HB-1:0]) * LB'(bfma_pkg::NEG_PINV[HB-1:0]);
            r4_q01 <= w_t0[HB-1:0] * bfma_pkg::NEG_PINV[LB-1:HB];
            r4_q10 <= w_t0[LB-1:HB] * bfma_pkg::NEG_PINV[HB-1:0];
            r5_t <= r4_t;
            r5_m <= r4_q00 + {r4_q01 + r4_q10, {HB{1'b0}}};
            r6_t <= r5_t;
            for (int j = 0; j < NL; j++) begin
                r6_pp[j] <= partials(r5_m, bfma_pkg::PRIME[j*LB +: LB]);
            end
            r7_t <= r6_t;
            for (int j = 0; j < NL; j++) begin
                r7_pr[j] <= combine(r6_pp[j]);
            end
            r8_t <= n_t8[LB +: AW];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_ctx   = r_ctx[NS-1];
    assign o_t     = r8_t;

endmodule

// ----- src/bfma_final.sv -----
// Final stages: add or subtract path, one conditional correction by p (mode 3 gives zero), and the output register.
module bfma_final (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  bfma_pkg::t_ctx                i_ctx,
    input  logic [bfma_pkg::ACC_BITS-1:0] i_t,
    output logic                          o_valid,
    output bfma_pkg::t_out                o_data
);

    localparam int WB = bfma_pkg::WORD_BITS;
    localparam int AW = bfma_pkg::ACC_BITS;
    localparam int LB = bfma_pkg::LIMB_BITS;

    logic          r1_valid;
    logic [1:0]    r1_mode;
    logic [AW-1:0] r1_v;
    logic          r2_valid;
    logic [WB-1:0] r2_r;
    logic [AW-1:0] n_v;
    logic [WB:0]   w_diff;
    logic [WB-1:0] n_r;

    assign w_diff = (WB+1)'(i_ctx.a) - (WB+1)'(i_ctx.b);

    always_comb begin
        case (i_ctx.mode)
            bfma_pkg::MODE_ADD: n_v = AW'(i_ctx.a) + AW'(i_ctx.b);
            bfma_pkg::MODE_SUB: n_v = AW'(w_diff);
            default:            n_v = i_t;
        endcase
    end

    always_comb begin
        case (r1_mode) inside
            bfma_pkg::MODE_SUB: begin
                n_r = r1_v[WB] ? r1_v[WB-1:0] + bfma_pkg::PRIME : r1_v[WB-1:0];
            end
            bfma_pkg::MODE_ADD, bfma_pkg::MODE_MUL: begin
                n_r = (r1_v >= AW'(bfma_pkg::PRIME)) ?
                      WB'(r1_v - AW'(bfma_pkg::PRIME)) : r1_v[WB-1:0];
            end
            default: n_r = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= i_ctx.mode;
            r1_v    <= n_v;
            r2_r    <= n_r;
        end
    end

    assign o_valid        = r2_valid;
    assign o_data.r_limb0 = r2_r[0*LB +: LB];
    assign o_data.r_limb1 = r2_r[1*LB +: LB];
    assign o_data.r_limb2 = r2_r[2*LB +: LB];
    assign o_data.r_limb3 = r2_r[3*LB +: LB];

endmodule

// ----- src/bn254_field_mont_alu.sv -----
// Top level of the BN254 scalar-field modular ALU (add, subtract, Montgomery multiply).
// The block accepts one transaction every cycle unless the output stall holds it, and
// returns results in order through four CIOS rounds of eight register stages each, built
// from 32x32-bit multipliers, followed by two stages for the add and subtract paths
// and the final correction by p. Every transaction passes through the same pipeline,
// whatever its mode. The pipeline advances as a whole; it holds while a result waits
// at the output under stall, and input stall is raised only then.
module bn254_field_mont_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bfma_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output bfma_pkg::t_out o_data
);

    localparam int NL = bfma_pkg::LIMB_COUNT;
    localparam int AW = bfma_pkg::ACC_BITS;

    logic           w_en;
    logic           w_v   [NL+1];
    bfma_pkg::t_ctx w_ctx [NL+1];
    logic [AW-1:0]  w_t   [NL+1];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_v[0]        = i_valid;
    assign w_ctx[0].mode = i_data.mode;
    assign w_ctx[0].a    = {i_data.a_limb3, i_data.a_limb2, i_data.a_limb1, i_data.a_limb0};
    assign w_ctx[0].b    = {i_data.b_limb3, i_data.b_limb2, i_data.b_limb1, i_data.b_limb0};
    assign w_t[0]        = '0;

    for (genvar g = 0; g < NL; g++) begin : g_round
        bfma_round #(
            .ROUND(g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_ctx   (w_ctx[g]),
            .i_t     (w_t[g]),
            .o_valid (w_v[g+1]),
            .o_ctx   (w_ctx[g+1]),
            .o_t     (w_t[g+1])
        );
    end

    bfma_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v[NL]),
        .i_ctx   (w_ctx[NL]),
        .i_t     (w_t[NL]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ----- sim/tb.sv -----
// Testbench for the BN254 scalar-field ALU: directed and random items, checked against a table or a predictor.
module tb;

    localparam logic [255:0] R2 =
        256'h0216d0b17f4e44a58c49833d53bb808553fe3ab1e35c59e31bb8e645ae216da7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    bfma_pkg::t_in  i_data = '0;
    logic o_stall;
    logic o_valid;
    bfma_pkg::t_out o_data;

    bn254_field_mont_alu DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    typedef struct {
        bfma_pkg::t_in  item;
        logic           known;
        bfma_pkg::t_out result;
    } t_row;

    bfma_pkg::t_out result_fifo[$];
    t_row rows[$];
    int   errors = 0;
    logic done_sending = 1'b0;
    int   quiet_in = 0;
    int   quiet_out = 0;
    int   out_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [255:0] word_a(bfma_pkg::t_in x);
        return {x.a_limb3, x.a_limb2, x.a_limb1, x.a_limb0};
    endfunction

    function automatic logic [255:0] word_b(bfma_pkg::t_in x);
        return {x.b_limb3, x.b_limb2, x.b_limb1, x.b_limb0};
    endfunction

    function automatic logic [255:0] sub_prime_once(logic [319:0] v);
        if (v >= {64'd0, bfma_pkg::PRIME}) begin
            v = v - {64'd0, bfma_pkg::PRIME};
        end
        return v[255:0];
    endfunction

    function automatic bfma_pkg::t_out predict_field_op(bfma_pkg::t_in x);
        logic [255:0] a, b, r;
        logic [383:0] acc;
        logic [63:0]  m;
        a = word_a(x);
        b = word_b(x);
        r = '0;
        case (x.mode)
            bfma_pkg::MODE_ADD: begin
                r = sub_prime_once({63'd0, {1'b0, a} + {1'b0, b}});
            end
            bfma_pkg::MODE_SUB: begin
                r = a - b;
                if (a < b) begin
                    r = r + bfma_pkg::PRIME;
                end
            end
            bfma_pkg::MODE_MUL: begin
                acc = '0;
                for (int i = 0; i < bfma_pkg::LIMB_COUNT; i++) begin
                    acc = acc + {128'd0, b} * a[64*i +: 64];
                    m = acc[63:0] * bfma_pkg::NEG_PINV;
                    acc = (acc + {128'd0, bfma_pkg::PRIME} * m) >> 64;
                end
                r = sub_prime_once(acc[319:0]);
            end
            default: r = '0;
        endcase
        return '{r_limb0: r[63:0], r_limb1: r[127:64], r_limb2: r[191:128],
                 r_limb3: r[255:192]};
    endfunction

    function automatic bfma_pkg::t_in make_item(logic [1:0] mode, logic [255:0] a,
                                                logic [255:0] b);
        return '{mode: mode, a_limb0: a[63:0], a_limb1: a[127:64], a_limb2: a[191:128],
                 a_limb3: a[255:192], b_limb0: b[63:0], b_limb1: b[127:64],
                 b_limb2: b[191:128], b_limb3: b[255:192]};
    endfunction

    function automatic logic [255:0] rand_word();
        logic [255:0] w;
        for (int i = 0; i < 8; i++) begin
            w[32*i +: 32] = $urandom;
        end
        return w;
    endfunction

    function automatic logic [255:0] rand_field();
        logic [255:0] w;
        case ($urandom_range(0, 5))
            0: w = bfma_pkg::PRIME - 256'($urandom_range(1, 4));
            1: w = 256'($urandom_range(0, 3));
            2: w = rand_word() >> $urandom_range(0, 255);
            default: w = rand_word() % bfma_pkg::PRIME;
        endcase
        return w;
    endfunction

    function automatic bfma_pkg::t_out word_out(logic [255:0] r);
        return '{r_limb0: r[63:0], r_limb1: r[127:64], r_limb2: r[191:128],
                 r_limb3: r[255:192]};
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [255:0] a, logic [255:0] b,
                                    logic known, logic [255:0] r);
        t_row row;
        row.item = make_item(mode, a, b);
        row.known = known;
        row.result = word_out(r);
        rows.push_back(row);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_cycles <= out_cycles + 1;
            if (quiet_out > 0) begin
                quiet_out <= quiet_out - 1;
                i_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 999) == 0 || out_cycles == 1000) begin
                    quiet_out <= 300;
                end
                i_stall <= ($urandom_range(0, 99) < 32);
            end
            if (o_valid && !i_stall) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t unexpected transaction, actual %h", $time, o_data);
                    errors++;
                end else begin
                    if (o_data !== result_fifo[0]) begin
                        $display("%0t mismatch, expected %h, actual %h", $time,
                                 result_fifo[0], o_data);
                        errors++;
                    end
                    void'(result_fifo.pop_front());
                end
            end
        end
    end

    initial begin
        t_row row;
        logic [255:0] pm1, a, b;
        int cnt, wait_cycles, drive_cycles;
        pm1 = bfma_pkg::PRIME - 1;
        add_row(bfma_pkg::MODE_ADD, 0, 0, 1, 0);
        add_row(bfma_pkg::MODE_ADD, pm1, 1, 1, 0);
        add_row(bfma_pkg::MODE_ADD, pm1, pm1, 1, bfma_pkg::PRIME - 2);
        add_row(bfma_pkg::MODE_SUB, 0, 1, 1, pm1);
        add_row(bfma_pkg::MODE_SUB, pm1, pm1, 1, 0);
        add_row(bfma_pkg::MODE_SUB, 0, pm1, 1, 1);
        add_row(bfma_pkg::MODE_MUL, 0, pm1, 1, 0);
        add_row(bfma_pkg::MODE_MUL, pm1, pm1, 0, 0);
        add_row(bfma_pkg::MODE_MUL, 1, R2, 0, 0);
        add_row(bfma_pkg::MODE_MUL, R2, R2, 0, 0);
        add_row(bfma_pkg::MODE_MUL, pm1, 1, 0, 0);
        add_row(2'd3, pm1, pm1, 1, 0);
        add_row(2'd3, '1, '1, 1, 0);
        add_row(bfma_pkg::MODE_ADD, '1, '1, 0, 0);
        add_row(bfma_pkg::MODE_SUB, 0, '1, 0, 0);
        add_row(bfma_pkg::MODE_SUB, '1, 0, 0, 0);
        add_row(bfma_pkg::MODE_MUL, '1, '1, 0, 0);
        add_row(bfma_pkg::MODE_ADD, bfma_pkg::PRIME, 0, 0, 0);
        add_row(bfma_pkg::MODE_MUL, bfma_pkg::PRIME, pm1, 0, 0);
        for (int k = 0; k < 1650; k++) begin
            a = rand_field();
            b = ($urandom_range(0, 7) == 0) ? a : rand_field();
            if ($urandom_range(0, 19) == 0) begin
                a = rand_word();
                b = rand_word();
            end
            add_row(2'($urandom_range(0, 3) == 3 ? ($urandom_range(0, 3) == 0 ? 3 : 2)
                       : $urandom_range(0, 2)), a, b, 0, 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cnt = 0;
        drive_cycles = 0;
        while (cnt < rows.size()) begin
            @(posedge i_clk);
            drive_cycles++;
            if (drive_cycles == 1000) begin
                quiet_in = 300;
            end
            if (i_valid && !o_stall) begin
                cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (cnt < rows.size() &&
                    (quiet_in > 0 || $urandom_range(0, 99) >= 32)) begin
                    row = rows[cnt];
                    i_valid <= 1'b1;
                    i_data <= row.item;
                    result_fifo.push_back(row.known ? row.result
                                                    : predict_field_op(row.item));
                end else begin
                    i_valid <= 1'b0;
                end
                if (quiet_in > 0) begin
                    quiet_in--;
                end else if ($urandom_range(0, 999) == 0) begin
                    quiet_in = 300;
                end
            end
        end
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (result_fifo.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (errors == 0 && result_fifo.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
